// File: hw/rtl/tvd_pkg.sv
`default_nettype none

package tvd_pkg;

  // Output format: unsigned Q(32-F).F
  localparam int unsigned DENSITY_FRAC_BITS = 16;
  localparam int unsigned JUT_SHIFT = 32 - DENSITY_FRAC_BITS;
  localparam int unsigned MB_SHIFT  = 48 - DENSITY_FRAC_BITS;

  localparam int unsigned SQRT_STEPS   = 32;  // one result bit per stage
  localparam int unsigned DIV_STEPS    = 48;  // gamma < 2^48 in Q.32
  localparam int unsigned K_BITS       = 6;   // range-reduction count, 0..32
  localparam int unsigned TAYLOR_TERMS = 12;

  localparam logic [31:0] DIV_INIT_REM = 32'd1 << (63 - DIV_STEPS);
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [63:0] EXP_CUTOFF   = 64'd33 * 64'd2977044472;
  localparam logic [62:0] ONE_Q62      = 63'd1 << 62;
  localparam logic [33:0] ONE_Q32      = 34'd1 << 32;
  localparam logic [31:0] BETA_NEG_ONE = 32'h8000_0000;

  // Register map
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_THETA = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MB_NORM   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MJ_NORM   = 2'd3;

  localparam logic        MODE_MB        = 1'b0;
  localparam logic        MODE_RESET     = 1'b1;
  localparam logic [31:0] INV_THETA_RESET = 32'd65536;
  localparam logic [31:0] MB_NORM_RESET   = 32'd26145;
  localparam logic [31:0] MJ_NORM_RESET   = 32'd54442;

endpackage

`default_nettype wire

// File: hw/rtl/thermal_velocity_density.sv
// Thermal velocity density. Each start with busy low takes one beta word
// and, at the end of the pipeline, done pulses for one cycle with density,
// saturated and domain_error. The pipeline takes a new word every cycle and
// never stalls, so busy stays low and done cannot be held off. Latency is set
// by the 32-stage square root and the 48-stage reciprocal that form gamma,
// the 6-stage ln2 range reduction and the 11 three-stage Taylor terms of exp.
// Write the configuration registers only with no word in flight.
`default_nettype none

module thermal_velocity_density (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire  [31:0]                     beta,
  output logic                            done,
  output logic [31:0]                     density,
  output logic                            saturated,
  output logic                            domain_error,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [tvd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [31:0]                     cfg_data
);
  import tvd_pkg::*;

  localparam int unsigned LATENCY = 3 + SQRT_STEPS + 1 + DIV_STEPS + 3 + 1 + K_BITS + 1
                                    + 3 * (TAYLOR_TERMS - 1) + 5;

  typedef struct packed {
    logic mode;
    logic dom;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [47:0] bx;   // Boltzmann exponent, Q.32
  } side_t;

  typedef struct packed {
    ctl_t        ctl;
    logic        big;
    logic [5:0]  k;
    logic [63:0] g3;
    logic [31:0] r;
  } pay_t;

  logic        accept;
  logic        mode;
  logic [31:0] inv_theta;
  logic [31:0] mb_norm;
  logic [31:0] mj_norm;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_RESET;
      inv_theta <= INV_THETA_RESET;
      mb_norm   <= MB_NORM_RESET;
      mj_norm   <= MJ_NORM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:      mode      <= cfg_data[0];
        REG_INV_THETA: inv_theta <= cfg_data;
        REG_MB_NORM:   mb_norm   <= cfg_data;
        REG_MJ_NORM:   mj_norm   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- front: |beta|, beta^2, Boltzmann exponent
  logic        s0_v;
  logic [31:0] s0_beta;
  logic        s1_v;
  ctl_t        s1_ctl;
  logic [62:0] s1_b2;
  logic [31:0] bmag;
  logic [63:0] bsq;
  logic [63:0] bprod;

  assign bmag  = s0_beta[31] ? (~s0_beta + 32'd1) : s0_beta;
  assign bsq   = 64'(bmag) * 64'(bmag);
  assign bprod = 64'(s1_b2[62:31]) * 64'(inv_theta);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
    end else begin
      s0_v <= accept;
      s1_v <= s0_v;
    end
    s0_beta     <= beta;
    s1_b2       <= bsq[62:0];
    s1_ctl.mode <= mode;
    s1_ctl.dom  <= mode && (s0_beta == BETA_NEG_ONE);
  end

  // ---- square root of 1 - beta^2, one bit per stage
  logic        sq_v    [SQRT_STEPS+1];
  side_t       sq_side [SQRT_STEPS+1];
  logic [62:0] sq_rem  [SQRT_STEPS+1];
  logic [62:0] sq_res  [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else     sq_v[0] <= s1_v;
    sq_rem[0]      <= ONE_Q62 - s1_b2;
    sq_res[0]      <= '0;
    sq_side[0].ctl <= s1_ctl;
    sq_side[0].bx  <= bprod[63:16];
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    logic        take;
    assign trial = {1'b0, sq_res[j]} + SQ_BIT;
    assign take  = {1'b0, sq_rem[j]} >= trial;
    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else     sq_v[j+1] <= sq_v[j];
      sq_side[j+1] <= sq_side[j];
      if (take) begin
        sq_rem[j+1] <= 63'({1'b0, sq_rem[j]} - trial);
        sq_res[j+1] <= 63'({2'b0, sq_res[j][62:1]} + SQ_BIT);
      end else begin
        sq_rem[j+1] <= sq_rem[j];
        sq_res[j+1] <= {1'b0, sq_res[j][62:1]};
      end
    end
  end

  // ---- gamma = 2^63 / s, restoring, one quotient bit per stage
  logic        dv_v    [DIV_STEPS+1];
  side_t       dv_side [DIV_STEPS+1];
  logic [31:0] dv_s    [DIV_STEPS+1];
  logic [31:0] dv_rem  [DIV_STEPS+1];
  logic [47:0] dv_q    [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= sq_v[SQRT_STEPS];
    dv_side[0] <= sq_side[SQRT_STEPS];
    dv_s[0]    <= sq_res[SQRT_STEPS][31:0];
    dv_rem[0]  <= DIV_INIT_REM;
    dv_q[0]    <= '0;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [32:0] r2;
    logic        ge;
    assign r2 = {dv_rem[i], 1'b0};
    assign ge = r2 >= {1'b0, dv_s[i]};
    always_ff @(posedge clk) begin
      if (rst) dv_v[i+1] <= 1'b0;
      else     dv_v[i+1] <= dv_v[i];
      dv_side[i+1] <= dv_side[i];
      dv_s[i+1]    <= dv_s[i];
      dv_rem[i+1]  <= ge ? 32'(r2 - {1'b0, dv_s[i]}) : r2[31:0];
      dv_q[i+1]    <= {dv_q[i][46:0], ge};
    end
  end

  // ---- exponent and gamma powers
  logic        x1_v, x2_v, x3_v;
  side_t       x1_side;
  ctl_t        x2_ctl, x3_ctl;
  logic [47:0] x1_g, x2_g;
  logic [63:0] x1_ph;
  logic [47:0] x1_pl;
  logic [63:0] x1_gp00;
  logic [47:0] x1_gp01;
  logic [31:0] x1_gp11;
  logic [63:0] x2_x;
  logic [63:0] x2_g2;
  logic        x3_big;
  logic [37:0] x3_kr;
  logic [63:0] x3_a0b0, x3_a1b0;
  logic [47:0] x3_a0b1, x3_a1b1;
  logic [47:0] gq;
  logic [95:0] g2_full;
  logic [111:0] g3_full;

  assign gq      = dv_q[DIV_STEPS];
  assign g2_full = {32'd0, x1_gp00} + ({48'd0, x1_gp01} << 33) + {x1_gp11, 64'd0};
  assign g3_full = {48'd0, x3_a0b0} + ({64'd0, x3_a0b1} << 32)
                 + ({48'd0, x3_a1b0} << 32) + ({64'd0, x3_a1b1} << 64);

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_v <= 1'b0;
      x2_v <= 1'b0;
      x3_v <= 1'b0;
    end else begin
      x1_v <= dv_v[DIV_STEPS];
      x2_v <= x1_v;
      x3_v <= x2_v;
    end
    x1_side <= dv_side[DIV_STEPS];
    x1_g    <= gq;
    x1_ph   <= 64'(gq[47:16]) * 64'(inv_theta);
    x1_pl   <= 48'(gq[15:0]) * 48'(inv_theta);
    x1_gp00 <= 64'(gq[31:0]) * 64'(gq[31:0]);
    x1_gp01 <= 48'(gq[31:0]) * 48'(gq[47:32]);
    x1_gp11 <= 32'(gq[47:32]) * 32'(gq[47:32]);

    x2_ctl <= x1_side.ctl;
    x2_g   <= x1_g;
    x2_x   <= (x1_side.ctl.mode == MODE_MB) ? {16'd0, x1_side.bx}
                                            : x1_ph + 64'(x1_pl[47:16]);
    x2_g2  <= g2_full[95:32];

    x3_ctl  <= x2_ctl;
    x3_big  <= x2_x >= EXP_CUTOFF;
    x3_kr   <= x2_x[37:0];
    x3_a0b0 <= 64'(x2_g2[31:0]) * 64'(x2_g[31:0]);
    x3_a0b1 <= 48'(x2_g2[31:0]) * 48'(x2_g[47:32]);
    x3_a1b0 <= 64'(x2_g2[63:32]) * 64'(x2_g[31:0]);
    x3_a1b1 <= 48'(x2_g2[63:32]) * 48'(x2_g[47:32]);
  end

  // ---- range reduction: k = x / ln2, r = x - k*ln2
  logic        kd_v   [K_BITS+1];
  ctl_t        kd_ctl [K_BITS+1];
  logic        kd_big [K_BITS+1];
  logic [37:0] kd_rem [K_BITS+1];
  logic [5:0]  kd_k   [K_BITS+1];
  logic [63:0] kd_g3  [K_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) kd_v[0] <= 1'b0;
    else     kd_v[0] <= x3_v;
    kd_ctl[0] <= x3_ctl;
    kd_big[0] <= x3_big;
    kd_rem[0] <= x3_kr;
    kd_k[0]   <= '0;
    kd_g3[0]  <= g3_full[111:48];
  end

  for (genvar j = 0; j < K_BITS; j++) begin : g_kred
    localparam logic [37:0] KSTEP = 38'(LN2_Q32) << (K_BITS - 1 - j);
    logic ge;
    assign ge = kd_rem[j] >= KSTEP;
    always_ff @(posedge clk) begin
      if (rst) kd_v[j+1] <= 1'b0;
      else     kd_v[j+1] <= kd_v[j];
      kd_ctl[j+1] <= kd_ctl[j];
      kd_big[j+1] <= kd_big[j];
      kd_g3[j+1]  <= kd_g3[j];
      kd_rem[j+1] <= ge ? kd_rem[j] - KSTEP : kd_rem[j];
      kd_k[j+1]   <= {kd_k[j][4:0], ge};
    end
  end

  // ---- exp(-r) Taylor sum; first two terms (1 - r) folded into the entry stage
  logic        tm_v   [TAYLOR_TERMS];
  pay_t        tm_p   [TAYLOR_TERMS];
  logic [31:0] tm_t   [TAYLOR_TERMS];
  logic [33:0] tm_sum [TAYLOR_TERMS];
  logic        ta_v   [TAYLOR_TERMS-1];
  pay_t        ta_p   [TAYLOR_TERMS-1];
  logic [33:0] ta_sum [TAYLOR_TERMS-1];
  logic [31:0] ta_tr  [TAYLOR_TERMS-1];
  logic        tb_v   [TAYLOR_TERMS-1];
  pay_t        tb_p   [TAYLOR_TERMS-1];
  logic [33:0] tb_sum [TAYLOR_TERMS-1];
  logic [31:0] tb_tr  [TAYLOR_TERMS-1];
  logic [31:0] tb_q0  [TAYLOR_TERMS-1];

  always_ff @(posedge clk) begin
    if (rst) tm_v[0] <= 1'b0;
    else     tm_v[0] <= kd_v[K_BITS];
    tm_p[0].ctl <= kd_ctl[K_BITS];
    tm_p[0].big <= kd_big[K_BITS];
    tm_p[0].k   <= kd_k[K_BITS];
    tm_p[0].g3  <= kd_g3[K_BITS];
    tm_p[0].r   <= kd_rem[K_BITS][31:0];
    tm_t[0]     <= kd_rem[K_BITS][31:0];
    tm_sum[0]   <= ONE_Q32 - 34'(kd_rem[K_BITS][31:0]);
  end

  for (genvar i = 1; i < TAYLOR_TERMS; i++) begin : g_term
    localparam int unsigned NDIV  = i + 1;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / NDIV);
    localparam bit          ODD   = (NDIV % 2) == 1;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [31:0] qn;
    logic [31:0] q;
    assign mul_a = 64'(tm_t[i-1]) * 64'(tm_p[i-1].r);
    assign mul_b = 64'(ta_tr[i-1]) * 64'(RECIP);
    // reciprocal estimate is low by at most one
    assign qn    = 32'(64'(tb_q0[i-1]) * 64'(NDIV));
    assign q     = tb_q0[i-1] + {31'd0, (tb_tr[i-1] - qn) >= 32'(NDIV)};
    always_ff @(posedge clk) begin
      if (rst) begin
        ta_v[i-1] <= 1'b0;
        tb_v[i-1] <= 1'b0;
        tm_v[i]   <= 1'b0;
      end else begin
        ta_v[i-1] <= tm_v[i-1];
        tb_v[i-1] <= ta_v[i-1];
        tm_v[i]   <= tb_v[i-1];
      end
      ta_p[i-1]   <= tm_p[i-1];
      ta_sum[i-1] <= tm_sum[i-1];
      ta_tr[i-1]  <= mul_a[63:32];
      tb_p[i-1]   <= ta_p[i-1];
      tb_sum[i-1] <= ta_sum[i-1];
      tb_tr[i-1]  <= ta_tr[i-1];
      tb_q0[i-1]  <= mul_b[63:32];
      tm_p[i]     <= tb_p[i-1];
      tm_t[i]     <= q;
      tm_sum[i]   <= ODD ? tb_sum[i-1] - 34'(q) : tb_sum[i-1] + 34'(q);
    end
  end

  // ---- scaling and normalization
  localparam int unsigned TL = TAYLOR_TERMS - 1;

  logic        e_v, t1_v, t2_v, t3_v;
  ctl_t        e_ctl, t1_ctl, t2_ctl, t3_ctl;
  logic [32:0] e_e;
  logic [63:0] e_g3, t1_g3;
  logic [63:0] t1_gpa, t1_gpb, t1_mp;
  logic        t1_e32;
  logic [63:0] t2_t;
  logic [64:0] t2_bp, t3_bp;
  logic [63:0] t3_tp0, t3_tp1;
  logic [95:0] t_full;
  logic [95:0] j_prod;
  logic [95:0] sel;
  logic        over;

  assign t_full = {32'd0, t1_gpa} + {t1_gpb, 32'd0} + (t1_e32 ? {t1_g3, 32'd0} : 96'd0);
  assign j_prod = {32'd0, t3_tp0} + {t3_tp1, 32'd0};
  assign sel    = (t3_ctl.mode == MODE_MB) ? ({31'd0, t3_bp} >> MB_SHIFT)
                                           : (j_prod >> JUT_SHIFT);
  assign over   = |sel[95:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v  <= 1'b0;
      t1_v <= 1'b0;
      t2_v <= 1'b0;
      t3_v <= 1'b0;
      done <= 1'b0;
    end else begin
      e_v  <= tm_v[TL];
      t1_v <= e_v;
      t2_v <= t1_v;
      t3_v <= t2_v;
      done <= t3_v;
    end
    e_ctl <= tm_p[TL].ctl;
    e_g3  <= tm_p[TL].g3;
    e_e   <= tm_p[TL].big ? 33'd0 : 33'(tm_sum[TL] >> tm_p[TL].k);

    t1_ctl <= e_ctl;
    t1_g3  <= e_g3;
    t1_e32 <= e_e[32];
    t1_gpa <= 64'(e_g3[31:0]) * 64'(e_e[31:0]);
    t1_gpb <= 64'(e_g3[63:32]) * 64'(e_e[31:0]);
    t1_mp  <= 64'(e_e[31:0]) * 64'(mb_norm);

    t2_ctl <= t1_ctl;
    t2_t   <= t_full[95:32];
    t2_bp  <= {1'b0, t1_mp} + (t1_e32 ? {1'b0, mb_norm, 32'd0} : 65'd0);

    t3_ctl <= t2_ctl;
    t3_bp  <= t2_bp;
    t3_tp0 <= 64'(t2_t[31:0]) * 64'(mj_norm);
    t3_tp1 <= 64'(t2_t[63:32]) * 64'(mj_norm);

    if (t3_ctl.dom) begin
      density      <= '0;
      saturated    <= 1'b0;
      domain_error <= 1'b1;
    end else begin
      density      <= over ? '1 : sel[31:0];
      saturated    <= over;
      domain_error <= 1'b0;
    end
  end

  // ---- checks
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result word without a matching start");

  a_domain : assert property (@(posedge clk) disable iff (rst)
    (done && domain_error) |-> (density == '0 && !saturated))
    else $error("domain error word carries a value");

  a_sat : assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (&density))
    else $error("saturated word not clamped");

  a_sqrt_range : assert property (@(posedge clk) disable iff (rst)
    (sq_v[SQRT_STEPS] && sq_side[SQRT_STEPS].ctl.mode && !sq_side[SQRT_STEPS].ctl.dom)
      |-> (sq_res[SQRT_STEPS][62:32] == '0 && sq_res[SQRT_STEPS][31:0] >= 32'd65535))
    else $error("sqrt result out of range, gamma divider would overflow");

  a_kred : assert property (@(posedge clk) disable iff (rst)
    (kd_v[K_BITS] && !kd_big[K_BITS]) |-> (kd_rem[K_BITS] < 38'(LN2_Q32)))
    else $error("range reduction left remainder above ln2");

endmodule

`default_nettype wire
